// ===== hdl/lscsw_pkg.sv =====
// shared types, codes and defaults for the line state cache with stale window
`default_nettype none
package lscsw_pkg;

    localparam int LINE_DEPTH = 4096;
    localparam int STATE_BITS = 32;

    // operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_EXTEND = 3'd2;
    localparam logic [2:0] OP_COMMIT = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_RESET  = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] line;
        logic [12:0] count;
        logic [31:0] state_value;
    } in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [12:0] first_stale_line;
        logic        stale_open;
        logic [12:0] stale_length;
        logic [12:0] line_total;
        logic [1:0]  status;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_SHIFT,
        S_FILL,
        S_FETCH,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic latch;
        logic plan;
        logic shift;
        logic fill;
        logic fetch;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_fetch;
        logic shift_busy;
        logic fill_busy;
    } stat_t;

endpackage
`default_nettype wire

// ===== hdl/lscsw_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module lscsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lscsw_ctrl.sv =====
// sequencing state machine: accept, plan, shift, fill, fetch, respond
`default_nettype none
module lscsw_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire lscsw_pkg::stat_t stat,
    output lscsw_pkg::cmd_t      cmd
);

    lscsw_pkg::fsm_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == lscsw_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lscsw_pkg::S_IDLE: begin
                if (s_valid) state_next = lscsw_pkg::S_PLAN;
            end
            lscsw_pkg::S_PLAN: begin
                state_next = stat.need_fetch ? lscsw_pkg::S_FETCH : lscsw_pkg::S_SHIFT;
            end
            lscsw_pkg::S_SHIFT: begin
                if (!stat.shift_busy) state_next = lscsw_pkg::S_FILL;
            end
            lscsw_pkg::S_FILL: begin
                if (!stat.fill_busy) state_next = lscsw_pkg::S_RESP;
            end
            lscsw_pkg::S_FETCH: begin
                state_next = lscsw_pkg::S_RESP;
            end
            lscsw_pkg::S_RESP: begin
                if (out_free) state_next = lscsw_pkg::S_IDLE;
            end
            default: begin
                state_next = lscsw_pkg::S_IDLE;
            end
        endcase
    end

    // commands and output valid
    always_comb begin
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            lscsw_pkg::S_IDLE:  cmd.latch = s_valid;
            lscsw_pkg::S_PLAN:  cmd.plan  = 1'b1;
            lscsw_pkg::S_SHIFT: cmd.shift = 1'b1;
            lscsw_pkg::S_FILL:  cmd.fill  = 1'b1;
            lscsw_pkg::S_FETCH: cmd.fetch = 1'b1;
            lscsw_pkg::S_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lscsw_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lscsw_dp.sv =====
// datapath: window registers, shift and fill sequencer, line store, result register
`default_nettype none
module lscsw_dp #(
    parameter int LINE_DEPTH = lscsw_pkg::LINE_DEPTH,
    parameter int STATE_BITS = lscsw_pkg::STATE_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lscsw_pkg::in_t   s_data,
    input  wire lscsw_pkg::cmd_t  cmd,
    output lscsw_pkg::stat_t      stat,
    output lscsw_pkg::out_t       m_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int XW = ((CW > 13) ? CW : 13) + 2;

    lscsw_pkg::in_t  item_reg, item_next;
    lscsw_pkg::out_t out_reg, out_next;
    logic [CW-1:0]   held_reg, held_next;
    logic [CW-1:0]   ss_reg, ss_next;
    logic [CW-1:0]   len_reg, len_next;
    logic            pres_reg, pres_next;
    logic [1:0]      status_reg, status_next;
    logic [31:0]     rv_reg, rv_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            down_reg, down_next;
    logic [CW-1:0]   delta_reg, delta_next;
    logic            pend_v_reg, pend_v_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;
    logic [AW-1:0]   fill_ptr_reg, fill_ptr_next;
    logic [CW-1:0]   fill_rem_reg, fill_rem_next;

    // ram ports
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [STATE_BITS-1:0] ram_wdata, ram_rdata;

    // widened operands
    logic [XW-1:0]         h, s, n, l, ln, c, wend, dep, avail, cd, ss1;
    logic [STATE_BITS-1:0] v;

    assign h     = XW'(held_reg);
    assign s     = XW'(ss_reg);
    assign n     = XW'(len_reg);
    assign ln    = XW'(item_reg.line);
    assign l     = ln + XW'(1);
    assign c     = XW'(item_reg.count);
    assign wend  = s + n;
    assign dep   = XW'(LINE_DEPTH);
    assign avail = h - l;
    assign cd    = (c > avail) ? avail : c;
    assign ss1   = s + XW'(1);
    assign v     = STATE_BITS'(item_reg.state_value);

    // status toward the controller
    always_comb begin
        stat.need_fetch = ((item_reg.op == lscsw_pkg::OP_READ) && (ln < h))
                       || ((item_reg.op == lscsw_pkg::OP_COMMIT) && pres_reg
                           && (s < h) && (len_reg == '0));
        stat.shift_busy = (rem_reg != '0) || pend_v_reg;
        stat.fill_busy  = (fill_rem_reg != '0);
    end

    assign item_next = cmd.latch ? s_data : item_reg;

    // main next-state logic
    always_comb begin
        held_next      = held_reg;
        ss_next        = ss_reg;
        len_next       = len_reg;
        pres_next      = pres_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        rd_ptr_next    = rd_ptr_reg;
        rem_next       = rem_reg;
        down_next      = down_reg;
        delta_next     = delta_reg;
        pend_v_next    = 1'b0;
        pend_addr_next = pend_addr_reg;
        fill_ptr_next  = fill_ptr_reg;
        fill_rem_next  = fill_rem_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = ss_reg[AW-1:0];
        ram_wdata      = v;
        ram_re         = 1'b0;
        ram_raddr      = rd_ptr_reg;

        if (cmd.plan) begin
            status_next   = lscsw_pkg::ST_DONE;
            rv_next       = '0;
            rem_next      = '0;
            fill_rem_next = '0;
            // read address for a read or a commit compare
            ram_re    = 1'b1;
            ram_raddr = (item_reg.op == lscsw_pkg::OP_READ) ? AW'(item_reg.line)
                                                             : ss_reg[AW-1:0];
            case (item_reg.op)
                lscsw_pkg::OP_INSERT: begin
                    if (l >= h) begin
                        status_next = lscsw_pkg::ST_IGNORED;
                    end else if ((c != '0) && (h + c > dep)) begin
                        status_next = lscsw_pkg::ST_CAPACITY;
                    end else begin
                        held_next     = CW'(h + c);
                        rd_ptr_next   = AW'(h - XW'(1));
                        rem_next      = (c != '0) ? CW'(h - l) : '0;
                        down_next     = 1'b1;
                        delta_next    = CW'(c);
                        fill_ptr_next = AW'(l);
                        fill_rem_next = CW'(c);
                        if (!pres_reg) begin
                            pres_next = 1'b1;
                            ss_next   = CW'(l);
                            len_next  = CW'(c);
                        end else if (l >= wend) begin
                            len_next = CW'(l + c - s);
                        end else if (l >= s) begin
                            len_next = CW'(n + c);
                        end else begin
                            len_next = CW'(n + s - l + c);
                            ss_next  = CW'(l);
                        end
                    end
                end
                lscsw_pkg::OP_DELETE: begin
                    if (l >= h) begin
                        status_next = lscsw_pkg::ST_IGNORED;
                    end else begin
                        held_next   = CW'(h - cd);
                        rd_ptr_next = AW'(l + cd);
                        rem_next    = (cd != '0) ? CW'(h - l - cd) : '0;
                        down_next   = 1'b0;
                        delta_next  = CW'(cd);
                        if (!pres_reg) begin
                            pres_next = 1'b1;
                            ss_next   = CW'(l);
                            len_next  = '0;
                        end else if (l < s) begin
                            if (l + cd <= s) begin
                                len_next = CW'(wend - l - cd);
                            end else if (l + cd <= wend) begin
                                len_next = CW'(wend - (l + cd));
                            end else begin
                                len_next = '0;
                            end
                            ss_next = CW'(l);
                        end else if (l < wend) begin
                            len_next = (l + cd < wend) ? CW'(n - cd) : CW'(l - s);
                        end else begin
                            len_next = CW'(l - s);
                        end
                    end
                end
                lscsw_pkg::OP_EXTEND: begin
                    if (ln < h) begin
                        status_next = lscsw_pkg::ST_DONE;
                    end else if (ln + XW'(1) > dep) begin
                        status_next = lscsw_pkg::ST_CAPACITY;
                    end else begin
                        held_next     = CW'(ln + XW'(1));
                        fill_ptr_next = AW'(h);
                        fill_rem_next = CW'(ln + XW'(1) - h);
                        if (!pres_reg) begin
                            pres_next = 1'b1;
                            ss_next   = CW'(h);
                            len_next  = CW'(ln + XW'(1) - h);
                        end else begin
                            len_next = (ln + XW'(1) > s) ? CW'(ln + XW'(1) - s) : '0;
                        end
                    end
                end
                lscsw_pkg::OP_COMMIT: begin
                    if (pres_reg) begin
                        if (s >= h) begin
                            pres_next = 1'b0;
                            ss_next   = held_reg;
                            len_next  = '0;
                        end else if (len_reg != '0) begin
                            // unconditional part of the window
                            ram_we    = 1'b1;
                            ram_waddr = ss_reg[AW-1:0];
                            ram_wdata = v;
                            if (ss1 >= h) begin
                                pres_next = 1'b0;
                                ss_next   = held_reg;
                                len_next  = '0;
                            end else begin
                                ss_next  = CW'(ss1);
                                len_next = CW'(n - XW'(1));
                            end
                        end
                    end
                end
                lscsw_pkg::OP_READ: begin
                    if (ln >= h) status_next = lscsw_pkg::ST_IGNORED;
                end
                lscsw_pkg::OP_RESET: begin
                    held_next = CW'(1);
                    ss_next   = CW'(1);
                    len_next  = '0;
                    pres_next = 1'b0;
                end
                default: begin
                    status_next = lscsw_pkg::ST_DONE;
                end
            endcase
        end

        // entry move, one read and one write per cycle
        if (cmd.shift) begin
            if (rem_reg != '0) begin
                ram_re         = 1'b1;
                ram_raddr      = rd_ptr_reg;
                rd_ptr_next    = down_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                rem_next       = rem_reg - CW'(1);
                pend_v_next    = 1'b1;
                pend_addr_next = down_reg ? rd_ptr_reg + AW'(delta_reg)
                                          : rd_ptr_reg - AW'(delta_reg);
            end
            if (pend_v_reg) begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
            end
        end

        // clear opened lines
        if (cmd.fill && (fill_rem_reg != '0)) begin
            ram_we        = 1'b1;
            ram_waddr     = fill_ptr_reg;
            ram_wdata     = '0;
            fill_ptr_next = fill_ptr_reg + AW'(1);
            fill_rem_next = fill_rem_reg - CW'(1);
        end

        // stored data back from the line store
        if (cmd.fetch) begin
            if (item_reg.op == lscsw_pkg::OP_READ) begin
                rv_next = (item_reg.line == '0) ? '0 : 32'(ram_rdata);
            end else if (ram_rdata != v) begin
                ram_we    = 1'b1;
                ram_waddr = ss_reg[AW-1:0];
                ram_wdata = v;
                if (ss1 >= h) begin
                    pres_next = 1'b0;
                    ss_next   = held_reg;
                    len_next  = '0;
                end else begin
                    ss_next = CW'(ss1);
                end
            end else begin
                pres_next = 1'b0;
                ss_next   = held_reg;
                len_next  = '0;
            end
        end

        // result register
        if (cmd.load_out) begin
            out_next.read_value       = rv_reg;
            out_next.first_stale_line = 13'(ss_reg);
            out_next.stale_open       = pres_reg;
            out_next.stale_length     = pres_reg ? 13'(len_reg) : '0;
            out_next.line_total       = 13'(held_reg);
            out_next.status           = status_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= CW'(1);
            ss_reg       <= CW'(1);
            len_reg      <= '0;
            pres_reg     <= 1'b0;
            rem_reg      <= '0;
            fill_rem_reg <= '0;
            pend_v_reg   <= 1'b0;
        end else begin
            held_reg     <= held_next;
            ss_reg       <= ss_next;
            len_reg      <= len_next;
            pres_reg     <= pres_next;
            rem_reg      <= rem_next;
            fill_rem_reg <= fill_rem_next;
            pend_v_reg   <= pend_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        out_reg       <= out_next;
        status_reg    <= status_next;
        rv_reg        <= rv_next;
        rd_ptr_reg    <= rd_ptr_next;
        down_reg      <= down_next;
        delta_reg     <= delta_next;
        pend_addr_reg <= pend_addr_next;
        fill_ptr_reg  <= fill_ptr_next;
    end

    lscsw_ram #(
        .WIDTH(STATE_BITS),
        .DEPTH(LINE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ===== hdl/line_state_cache_stale_window.sv =====
// top level: line state cache with stale window tracking
//
//  channel | ports                       | payload
//  input   | s_valid / s_ready / s_data  | lscsw_pkg::in_t  (op, line, count, state_value)
//  result  | m_valid / m_ready / m_data  | lscsw_pkg::out_t (one result per transaction)
//
// a read inside the store and a commit that compares pass through plan, fetch and response,
// every other transaction through plan, shift, fill and response; m_valid rises in the
// cycle s_ready returns. insert moves the lines after the point and clears count new
// lines, delete moves the lines after the deleted ones, extend clears the lines opened:
// each line moved or cleared takes the single write port of the line store.
// reset leaves the store as is; line 0 always reads as zero.
// s_ready is low while a transaction is in work; one finished result may wait in
// the output register while the next transaction is accepted, and a second finished
// result waits in the response state until that register is taken.
`default_nettype none
module line_state_cache_stale_window #(
    parameter int LINE_DEPTH = lscsw_pkg::LINE_DEPTH,
    parameter int STATE_BITS = lscsw_pkg::STATE_BITS
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lscsw_pkg::in_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lscsw_pkg::out_t     m_data
);

    lscsw_pkg::cmd_t  cmd;
    lscsw_pkg::stat_t stat;

    lscsw_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    lscsw_dp #(
        .LINE_DEPTH(LINE_DEPTH),
        .STATE_BITS(STATE_BITS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .m_data (m_data)
    );

endmodule
`default_nettype wire

// ===== hdl/lscsw_checker.sv =====
// port level checks for the line state cache and their bind
`default_nettype none
module lscsw_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire lscsw_pkg::out_t m_data,
    input wire logic            m_valid,
    input wire logic            m_ready
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // closed window sits at the end of the store with no length
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.stale_open |->
            (m_data.stale_length == '0) && (m_data.first_stale_line == m_data.line_total))
        else $error("closed window not at end of store");

    // the store never empties and status stays in its codes
    a_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.line_total != '0) && (m_data.status != 2'd3))
        else $error("bad line total or status");

    // only a read can return a value; any refused transaction returns zero
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == lscsw_pkg::ST_IGNORED) |-> m_data.read_value == '0)
        else $error("refused transaction returned data");

    // no new transaction is taken in the cycle right after one is taken
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

endmodule

bind line_state_cache_stale_window lscsw_checker u_lscsw_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_data (m_data),
    .m_valid(m_valid),
    .m_ready(m_ready)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the line state cache with stale window: directed and random tests
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lscsw_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lscsw_pkg::out_t m_data;

    // idle percentages for sender and receiver
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // shadow copy of the cache state
    logic [31:0] shadow_store [lscsw_pkg::LINE_DEPTH];
    int unsigned held_lines;
    int unsigned win_start;
    int unsigned win_len;
    bit          win_open;

    lscsw_pkg::out_t pending_results [$];

    line_state_cache_stale_window uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        lscsw_pkg::out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_data !== exp_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rd=%h fs=%0d so=%b sl=%0d lt=%0d st=%0d",
                            exp_res.read_value, exp_res.first_stale_line,
                            exp_res.stale_open, exp_res.stale_length,
                            exp_res.line_total, exp_res.status,
                            " / got rd=%h fs=%0d so=%b sl=%0d lt=%0d st=%0d",
                            m_data.read_value, m_data.first_stale_line,
                            m_data.stale_open, m_data.stale_length,
                            m_data.line_total, m_data.status);
                end
            end
        end
    end

    function automatic void close_window();
        win_open = 0;
        win_start = held_lines;
        win_len = 0;
    endfunction

    function automatic void clear_cache();
        shadow_store[0] = '0;
        held_lines = 1;
        win_start = 1;
        win_len = 0;
        win_open = 0;
    endfunction

    function automatic logic [1:0] apply_insert(int unsigned l, int unsigned cnt);
        int unsigned wend;
        if (l >= held_lines) return lscsw_pkg::ST_IGNORED;
        if (cnt != 0) begin
            if (held_lines + cnt > lscsw_pkg::LINE_DEPTH) return lscsw_pkg::ST_CAPACITY;
            for (int i = held_lines - 1; i >= int'(l); i--) shadow_store[i + cnt] = shadow_store[i];
            for (int unsigned i = l; i < l + cnt; i++) shadow_store[i] = '0;
            held_lines += cnt;
        end
        wend = win_start + win_len;
        if (!win_open) begin
            win_open = 1; win_start = l; win_len = cnt;
        end else if (l >= wend) begin
            win_len = l + cnt - win_start;
        end else if (l >= win_start) begin
            win_len += cnt;
        end else begin
            win_len += win_start - l + cnt;
            win_start = l;
        end
        return lscsw_pkg::ST_DONE;
    endfunction

    function automatic logic [1:0] apply_delete(int unsigned l, int unsigned cnt);
        int unsigned wend;
        if (l >= held_lines) return lscsw_pkg::ST_IGNORED;
        if (cnt > held_lines - l) cnt = held_lines - l;
        if (cnt != 0) begin
            for (int unsigned i = l; i < held_lines - cnt; i++) shadow_store[i] = shadow_store[i + cnt];
            held_lines -= cnt;
        end
        wend = win_start + win_len;
        if (!win_open) begin
            win_open = 1; win_start = l; win_len = 0;
        end else if (l < win_start) begin
            if (l + cnt <= win_start) win_len = wend - l - cnt;
            else if (l + cnt <= wend) win_len = wend - (l + cnt);
            else win_len = 0;
            win_start = l;
        end else if (l < wend) begin
            if (l + cnt < wend) win_len -= cnt;
            else win_len = l - win_start;
        end else begin
            win_len = l - win_start;
        end
        return lscsw_pkg::ST_DONE;
    endfunction

    function automatic logic [1:0] apply_extend(int unsigned target);
        int unsigned old_lines;
        old_lines = held_lines;
        if (target < held_lines) return lscsw_pkg::ST_DONE;
        if (target + 1 > lscsw_pkg::LINE_DEPTH) return lscsw_pkg::ST_CAPACITY;
        for (int unsigned i = old_lines; i <= target; i++) shadow_store[i] = '0;
        held_lines = target + 1;
        if (!win_open) begin
            win_open = 1; win_start = old_lines; win_len = held_lines - old_lines;
        end else begin
            win_len = (held_lines > win_start) ? held_lines - win_start : 0;
        end
        return lscsw_pkg::ST_DONE;
    endfunction

    function automatic void apply_commit(logic [31:0] v);
        int unsigned ln;
        if (!win_open) return;
        ln = win_start;
        if (ln >= held_lines) begin
            close_window();
            return;
        end
        if (win_len > 0) begin
            shadow_store[ln] = v; win_start = ln + 1; win_len--;
        end else if (shadow_store[ln] != v) begin
            shadow_store[ln] = v; win_start = ln + 1;
        end else begin
            close_window();
            return;
        end
        if (win_start >= held_lines) close_window();
    endfunction

    // predict the result of one transaction
    function automatic lscsw_pkg::out_t predict_result(lscsw_pkg::in_t t);
        lscsw_pkg::out_t r;
        r = '0;
        case (t.op)
            lscsw_pkg::OP_INSERT: r.status = apply_insert(t.line + 1, t.count);
            lscsw_pkg::OP_DELETE: r.status = apply_delete(t.line + 1, t.count);
            lscsw_pkg::OP_EXTEND: r.status = apply_extend(t.line);
            lscsw_pkg::OP_COMMIT: apply_commit(t.state_value);
            lscsw_pkg::OP_READ: begin
                if (t.line < held_lines) r.read_value = shadow_store[t.line];
                else r.status = lscsw_pkg::ST_IGNORED;
            end
            lscsw_pkg::OP_RESET: clear_cache();
            default: ;
        endcase
        r.first_stale_line = win_start[12:0];
        r.stale_open = win_open;
        r.stale_length = win_open ? win_len[12:0] : 13'd0;
        r.line_total = held_lines[12:0];
        return r;
    endfunction

    // send one transaction and record its expected result
    task automatic send_item(logic [2:0] op, logic [11:0] line, logic [12:0] cnt,
                             logic [31:0] val);
        lscsw_pkg::in_t t;
        t = '{op: op, line: line, count: cnt, state_value: val};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        pending_results.push_back(predict_result(t));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // read any line, mostly inside the store
    task automatic read_some();
        send_item(lscsw_pkg::OP_READ, 12'($urandom_range(held_lines)), 13'($urandom),
            $urandom);
    endtask

    // extremes of every field and each special case
    task automatic test_directed();
        send_item(lscsw_pkg::OP_READ, 12'd0, 13'h1fff, 32'hffffffff);
        send_item(lscsw_pkg::OP_READ, 12'd4095, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_COMMIT, 12'd0, 13'd0, 32'h5);
        send_item(lscsw_pkg::OP_INSERT, 12'd0, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_INSERT, 12'd7, 13'd3, 32'd0);
        send_item(lscsw_pkg::OP_EXTEND, 12'd9, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_EXTEND, 12'd3, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_COMMIT, 12'd0, 13'd0, 32'hffffffff);
        send_item(lscsw_pkg::OP_COMMIT, 12'd0, 13'd0, 32'h0);
        send_item(lscsw_pkg::OP_INSERT, 12'd2, 13'd2, 32'd0);
        send_item(lscsw_pkg::OP_DELETE, 12'd0, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_DELETE, 12'd3, 13'h1fff, 32'd0);
        send_item(lscsw_pkg::OP_READ, 12'd1, 13'd0, 32'd0);
        repeat (6) send_item(lscsw_pkg::OP_COMMIT, 12'd0, 13'd0, 32'ha5a5a5a5);
        send_item(lscsw_pkg::OP_EXTEND, 12'd4095, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_INSERT, 12'd0, 13'd1, 32'd0);
        send_item(lscsw_pkg::OP_EXTEND, 12'd4095, 13'd0, 32'd0);
        send_item(lscsw_pkg::OP_DELETE, 12'd0, 13'd4096, 32'd0);
        send_item(lscsw_pkg::OP_RESET, 12'hfff, 13'h1fff, 32'hffffffff);
        send_item(3'd6, 12'd0, 13'd0, 32'd0);
        send_item(3'd7, 12'hfff, 13'h1fff, 32'hffffffff);
    endtask

    // random edit and recompute sessions, reads the most common kind
    task automatic test_random(int unsigned n);
        int unsigned k;
        for (int unsigned i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 35) read_some();
            else if (k < 55) send_item(lscsw_pkg::OP_COMMIT, 12'($urandom), 13'($urandom),
                ($urandom_range(1) ? 32'd0 : $urandom));
            else if (k < 67) send_item(lscsw_pkg::OP_INSERT, 12'($urandom_range(held_lines)),
                ($urandom_range(30) == 0) ? 13'($urandom) : 13'($urandom_range(6)), $urandom);
            else if (k < 79) send_item(lscsw_pkg::OP_DELETE, 12'($urandom_range(held_lines)),
                ($urandom_range(30) == 0) ? 13'($urandom) : 13'($urandom_range(6)), $urandom);
            else if (k < 90) send_item(lscsw_pkg::OP_EXTEND,
                ($urandom_range(20) == 0) ? 12'($urandom) : 12'(held_lines + $urandom_range(8)),
                13'($urandom), $urandom);
            else if (k < 93) send_item(lscsw_pkg::OP_RESET, 12'($urandom), 13'($urandom),
                $urandom);
            else if (k < 95) send_item(3'($urandom_range(7, 6)), 12'($urandom), 13'($urandom),
                $urandom);
            else send_item(lscsw_pkg::OP_READ, 12'($urandom), 13'($urandom), $urandom);
        end
    endtask

    // random traffic under each idling pattern
    task automatic test_idling();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(200);
        send_idle_pct = 56; recv_stall_pct = 0;  test_random(200);
        send_idle_pct = 0;  recv_stall_pct = 56; test_random(200);
        send_idle_pct = 30; recv_stall_pct = 30; test_random(200);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(100);
    endtask

    initial begin
        clear_cache();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_idling();
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/lscsw_pkg.sv
hdl/lscsw_ram.sv
hdl/lscsw_ctrl.sv
hdl/lscsw_dp.sv
hdl/line_state_cache_stale_window.sv
hdl/lscsw_checker.sv
dv/tb_top.sv
